// File: sv/cosine_track_matcher_assert.svh
`ifndef COSINE_TRACK_MATCHER_ASSERT_SVH
`define COSINE_TRACK_MATCHER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CTM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/ctm_pkg.sv
package ctm_pkg;

  localparam int FEATURE_LEN_DEF = 256;
  localparam int MAX_TRACKS_DEF  = 64;

  localparam logic [1:0] ACT_MATCH = 2'd0;
  localparam logic [1:0] ACT_NEW   = 2'd1;
  localparam logic [1:0] ACT_KEEP  = 2'd2;

  localparam logic [1:0] REG_MAX_TRACKS  = 2'd0;
  localparam logic [1:0] REG_SAME_THRESH = 2'd1;
  localparam logic [1:0] REG_NEW_THRESH  = 2'd2;

  localparam logic [6:0]  MAX_TRACKS_RST  = 7'd64;
  localparam logic [15:0] SAME_THRESH_RST = 16'd58982;
  localparam logic [15:0] NEW_THRESH_RST  = 16'd19661;

  typedef struct packed {
    logic acc;
    logic first;
    logic load;
    logic shift;
    logic ram_we;
    logic upd;
    logic evict;
  } cell_ctrl_t;

endpackage

// File: sv/ctm_ram.sv
module ctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ctm_cell.sv
module ctm_cell import ctm_pkg::*; #(
  parameter int FEATURE_LEN = FEATURE_LEN_DEF,
  parameter int SLOT_W      = 6,
  parameter int SLOT        = 0,
  localparam int IDX_W      = $clog2(FEATURE_LEN),
  localparam int SUM_W      = $clog2(FEATURE_LEN) + 15
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]        addr,
  input  logic [7:0]              wdata,
  input  logic signed [7:0]       q,
  input  logic [SLOT_W-1:0]       tgt_slot,
  input  logic [SLOT_W-1:0]       ev_slot,
  input  logic [31:0]             upd_id,
  input  logic [31:0]             upd_stamp,
  input  logic [SUM_W-1:0]        upd_nb,
  input  logic                    nxt_valid,
  input  logic signed [SUM_W:0]   nxt_dot,
  input  logic [SUM_W-1:0]        nxt_nb,
  input  logic [31:0]             nxt_id,
  input  logic [31:0]             nxt_stamp,
  output logic                    rec_valid,
  output logic signed [SUM_W:0]   rec_dot,
  output logic [SUM_W-1:0]        rec_nb,
  output logic [31:0]             rec_id,
  output logic [31:0]             rec_stamp
);

  logic                  valid_r;
  logic [31:0]           id_r;
  logic [31:0]           stamp_r;
  logic [SUM_W-1:0]      nb_r;
  logic signed [SUM_W:0] dot_r;
  logic signed [SUM_W:0] dot_nxt;
  logic [7:0]            rd;
  logic signed [15:0]    prod;
  logic                  hit_tgt;
  logic                  hit_ev;

  assign hit_tgt = (tgt_slot == SLOT_W'(SLOT));
  assign hit_ev  = (ev_slot == SLOT_W'(SLOT));

  ctm_ram #(.WIDTH(8), .DEPTH(FEATURE_LEN)) u_ram (
    .clk   (clk),
    .we    (ctrl.ram_we && hit_tgt),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rd)
  );

  assign prod    = q * $signed(rd);
  assign dot_nxt = ctrl.first ? (SUM_W+1)'(prod) : dot_r + (SUM_W+1)'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (ctrl.upd && hit_tgt) begin
        valid_r <= 1'b1;
      end else if (ctrl.evict && hit_ev) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && hit_tgt) begin
      id_r    <= upd_id;
      stamp_r <= upd_stamp;
      nb_r    <= upd_nb;
    end
    if (ctrl.acc) begin
      dot_r <= dot_nxt;
    end
    if (ctrl.load) begin
      rec_valid <= valid_r;
      rec_dot   <= dot_r;
      rec_nb    <= nb_r;
      rec_id    <= id_r;
      rec_stamp <= stamp_r;
    end else if (ctrl.shift) begin
      rec_valid <= nxt_valid;
      rec_dot   <= nxt_dot;
      rec_nb    <= nxt_nb;
      rec_id    <= nxt_id;
      rec_stamp <= nxt_stamp;
    end
  end

endmodule

// File: sv/cosine_track_matcher.sv
// Cosine-similarity track matcher. Query elements arrive one item at a time, and the next is
// not taken until the current one is accumulated: every track cell reads its stored element
// and accumulates the dot product in parallel. The item carrying the last mark then starts a
// scan: the records shift down the cell chain into the shared exact comparator, one cell
// record per square, multiply and compare pass, followed by the threshold multiplies.
// When the query is stored or overwrites a track, a copy moves it from the query buffer into
// that cell's memory, after the result is posted. No clearing pass is needed after reset.
module cosine_track_matcher import ctm_pkg::*; #(
  parameter int FEATURE_LEN = FEATURE_LEN_DEF,
  parameter int MAX_TRACKS  = MAX_TRACKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_feature_value,
  input  logic              in_last_element,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_track_id,
  output logic [1:0]        out_action,
  output logic              out_evicted,
  output logic [31:0]       out_evicted_id,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W  = $clog2(FEATURE_LEN);
  localparam int EI_W   = $clog2(FEATURE_LEN + 1);
  localparam int SUM_W  = $clog2(FEATURE_LEN) + 15;
  localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int THR_W  = 2 * SUM_W + 32;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_ACC  = 14'b00000000000010,
    S_LOAD = 14'b00000000000100,
    S_SQ   = 14'b00000000001000,
    S_MUL  = 14'b00000000010000,
    S_CMP  = 14'b00000000100000,
    S_T0   = 14'b00000001000000,
    S_T1   = 14'b00000010000000,
    S_T2   = 14'b00000100000000,
    S_T3   = 14'b00001000000000,
    S_T4   = 14'b00010000000000,
    S_DEC  = 14'b00100000000000,
    S_POST = 14'b01000000000000,
    S_COPY = 14'b10000000000000
  } st_t;

  st_t st_r, st_nxt;

  logic [6:0]  max_tracks_r;
  logic [15:0] same_thresh_r;
  logic [15:0] new_thresh_r;

  logic [EI_W-1:0]   eidx_r;
  logic [EI_W-1:0]   nlen_r;
  logic signed [7:0] q_r;
  logic              inr_r, first_r, last_r;
  logic [SUM_W-1:0]  qn_r;
  logic [31:0]       vc_r, next_id_r;
  logic [SLOT_W-1:0] scan_r;

  logic                  cand_valid_r, cand_elig_r;
  logic [SUM_W-1:0]      cand_nb_r;
  logic [31:0]           cand_id_r, cand_stamp_r;
  logic [2*SUM_W-1:0]    d2c_r;
  logic                  best_found_r;
  logic [2*SUM_W-1:0]    best_d2_r;
  logic [SUM_W-1:0]      best_nb_r;
  logic [31:0]           best_id_r;
  logic [SLOT_W-1:0]     best_slot_r;
  logic [2*SUM_W-1:0]    lph_r, lpl_r, rph_r, rpl_r;
  logic [3*SUM_W-1:0]    lp, rp;
  logic                  old_found_r;
  logic [31:0]           old_age_r, old_id_r;
  logic [SLOT_W-1:0]     old_slot_r;
  logic                  free_found_r;
  logic [SLOT_W-1:0]     free_slot_r;
  logic [CNT_W-1:0]      count_r;

  logic [2*SUM_W-1:0]  qnnb_r;
  logic [31:0]         tts_r, ttn_r;
  logic [SUM_W+31:0]   plo_s_r, plo_n_r, phi_s_r, phi_n_r;
  logic [THR_W-1:0]    rs_r, rn_r;
  logic                gt_same_r, lt_new_r;

  logic [31:0]       res_id_r, res_evid_r;
  logic [1:0]        res_act_r;
  logic              res_ev_r, store_r;
  logic [SLOT_W-1:0] tgt_slot_r;

  logic [EI_W-1:0]  cp_r;
  logic [IDX_W-1:0] cp_d_r;
  logic             cp_v_r, cp_in_r;

  logic              out_valid_r;
  logic [31:0]       out_id_r, out_evid_r;
  logic [1:0]        out_act_r;
  logic              out_ev_r;

  logic              in_acc;
  logic              in_range;
  logic [7:0]        qbuf_rd;
  logic [15:0]       sq;
  cell_ctrl_t        ctrl;
  logic [IDX_W-1:0]  cell_addr;
  logic [7:0]        cell_wdata;
  logic [SLOT_W-1:0] cell_tgt;
  logic [31:0]       dec_id, dec_nid, age;
  logic [1:0]        dec_act;
  logic              dec_ev, dec_store, take, mt_big, post_go;
  logic [SLOT_W-1:0] dec_slot;
  logic [CNT_W-1:0]  cap;
  logic [THR_W-1:0]  d2x;

  logic                  ch_valid [MAX_TRACKS+1];
  logic signed [SUM_W:0] ch_dot   [MAX_TRACKS+1];
  logic [SUM_W-1:0]      ch_nb    [MAX_TRACKS+1];
  logic [31:0]           ch_id    [MAX_TRACKS+1];
  logic [31:0]           ch_stamp [MAX_TRACKS+1];

  assign in_ready  = (st_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = (eidx_r < EI_W'(FEATURE_LEN));
  assign out_valid = out_valid_r;
  assign out_track_id   = out_id_r;
  assign out_action     = out_act_r;
  assign out_evicted    = out_ev_r;
  assign out_evicted_id = out_evid_r;
  assign pready = 1'b1;
  assign post_go = !out_valid_r || out_ready;

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_TRACKS:  prdata = {25'd0, max_tracks_r};
      REG_SAME_THRESH: prdata = {16'd0, same_thresh_r};
      REG_NEW_THRESH:  prdata = {16'd0, new_thresh_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tracks_r  <= MAX_TRACKS_RST;
      same_thresh_r <= SAME_THRESH_RST;
      new_thresh_r  <= NEW_THRESH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MAX_TRACKS:  max_tracks_r  <= pwdata[6:0];
        REG_SAME_THRESH: same_thresh_r <= pwdata[15:0];
        REG_NEW_THRESH:  new_thresh_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  ctm_ram #(.WIDTH(8), .DEPTH(FEATURE_LEN)) u_qbuf (
    .clk   (clk),
    .we    (in_acc && in_range),
    .waddr (eidx_r[IDX_W-1:0]),
    .wdata (in_feature_value),
    .raddr (cp_r[IDX_W-1:0]),
    .rdata (qbuf_rd)
  );

  assign ch_valid[MAX_TRACKS] = 1'b0;
  assign ch_dot[MAX_TRACKS]   = '0;
  assign ch_nb[MAX_TRACKS]    = '0;
  assign ch_id[MAX_TRACKS]    = '0;
  assign ch_stamp[MAX_TRACKS] = '0;

  for (genvar k = 0; k < MAX_TRACKS; k++) begin : g_cell
    ctm_cell #(.FEATURE_LEN(FEATURE_LEN), .SLOT_W(SLOT_W), .SLOT(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .addr      (cell_addr),
      .wdata     (cell_wdata),
      .q         (q_r),
      .tgt_slot  (cell_tgt),
      .ev_slot   (old_slot_r),
      .upd_id    (dec_id),
      .upd_stamp (vc_r),
      .upd_nb    (qn_r),
      .nxt_valid (ch_valid[k+1]),
      .nxt_dot   (ch_dot[k+1]),
      .nxt_nb    (ch_nb[k+1]),
      .nxt_id    (ch_id[k+1]),
      .nxt_stamp (ch_stamp[k+1]),
      .rec_valid (ch_valid[k]),
      .rec_dot   (ch_dot[k]),
      .rec_nb    (ch_nb[k]),
      .rec_id    (ch_id[k]),
      .rec_stamp (ch_stamp[k])
    );
  end

  assign cell_addr  = (st_r == S_COPY) ? cp_d_r : eidx_r[IDX_W-1:0];
  assign cell_wdata = cp_in_r ? qbuf_rd : 8'd0;
  assign cell_tgt   = (st_r == S_COPY) ? tgt_slot_r : dec_slot;

  always_comb begin
    ctrl        = '0;
    ctrl.acc    = (st_r == S_ACC) && inr_r;
    ctrl.first  = first_r;
    ctrl.load   = (st_r == S_LOAD);
    ctrl.shift  = (st_r == S_SQ);
    ctrl.ram_we = (st_r == S_COPY) && cp_v_r;
    ctrl.upd    = (st_r == S_DEC) && dec_store;
    ctrl.evict  = (st_r == S_DEC) && dec_ev;
  end

  assign sq     = 16'(q_r * q_r);
  assign age    = vc_r - cand_stamp_r;
  assign lp     = {lph_r, SUM_W'(0)} + (3*SUM_W)'(lpl_r);
  assign rp     = {rph_r, SUM_W'(0)} + (3*SUM_W)'(rpl_r);
  assign take   = cand_elig_r && (!best_found_r || (lp > rp) ||
                  ((lp == rp) && (cand_id_r < best_id_r)));
  assign mt_big = {25'd0, max_tracks_r} > 32'(MAX_TRACKS);
  assign cap    = (max_tracks_r == 7'd0) ? CNT_W'(1) :
                  (mt_big ? CNT_W'(MAX_TRACKS) : CNT_W'(max_tracks_r));
  assign d2x    = {best_d2_r, 32'd0};
  assign dec_nid = ((next_id_r + 32'd1) == 32'd0) ? 32'd1 : next_id_r + 32'd1;

  always_comb begin
    dec_act   = ACT_KEEP;
    dec_id    = best_found_r ? best_id_r : 32'd0;
    dec_ev    = 1'b0;
    dec_store = 1'b0;
    dec_slot  = best_slot_r;
    if (gt_same_r) begin
      dec_act   = ACT_MATCH;
      dec_id    = best_id_r;
      dec_store = 1'b1;
    end else if (lt_new_r) begin
      dec_act   = ACT_NEW;
      dec_id    = dec_nid;
      dec_store = 1'b1;
      dec_ev    = (count_r >= cap) && old_found_r;
      if (dec_ev && (!free_found_r || (old_slot_r < free_slot_r))) begin
        dec_slot = old_slot_r;
      end else begin
        dec_slot = free_slot_r;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = S_ACC;
      S_ACC:  st_nxt = last_r ? S_LOAD : S_IDLE;
      S_LOAD: st_nxt = S_SQ;
      S_SQ:   st_nxt = S_MUL;
      S_MUL:  st_nxt = S_CMP;
      S_CMP:  st_nxt = (scan_r == SLOT_W'(MAX_TRACKS - 1)) ? S_T0 : S_SQ;
      S_T0:   st_nxt = S_T1;
      S_T1:   st_nxt = S_T2;
      S_T2:   st_nxt = S_T3;
      S_T3:   st_nxt = S_T4;
      S_T4:   st_nxt = S_DEC;
      S_DEC:  st_nxt = S_POST;
      S_POST: if (post_go) st_nxt = store_r ? S_COPY : S_IDLE;
      S_COPY: if (cp_r == EI_W'(FEATURE_LEN)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      eidx_r      <= '0;
      vc_r        <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      cp_v_r      <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc && in_range) begin
        eidx_r <= eidx_r + EI_W'(1);
      end
      if ((st_r == S_ACC) && last_r) begin
        eidx_r <= '0;
      end
      if (st_r == S_LOAD) begin
        vc_r <= vc_r + 32'd1;
      end
      if ((st_r == S_DEC) && !gt_same_r && lt_new_r) begin
        next_id_r <= dec_nid;
      end
      if ((st_r == S_POST) && post_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == S_POST) begin
        cp_v_r <= 1'b0;
      end else if (st_r == S_COPY) begin
        cp_v_r <= (cp_r < EI_W'(FEATURE_LEN));
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          q_r     <= in_feature_value;
          inr_r   <= in_range;
          first_r <= (eidx_r == '0);
          last_r  <= in_last_element;
        end
      end
      S_ACC: begin
        if (inr_r) begin
          qn_r <= first_r ? SUM_W'(sq) : qn_r + SUM_W'(sq);
        end
        nlen_r <= eidx_r;
      end
      S_LOAD: begin
        best_found_r <= 1'b0;
        old_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        count_r      <= '0;
        scan_r       <= '0;
      end
      S_SQ: begin
        cand_valid_r <= ch_valid[0];
        cand_elig_r  <= ch_valid[0] && (ch_dot[0] > 0) && (ch_nb[0] != '0) && (qn_r != '0);
        cand_nb_r    <= ch_nb[0];
        cand_id_r    <= ch_id[0];
        cand_stamp_r <= ch_stamp[0];
        d2c_r        <= ch_dot[0][SUM_W-1:0] * ch_dot[0][SUM_W-1:0];
      end
      S_MUL: begin
        lph_r <= d2c_r[2*SUM_W-1:SUM_W] * best_nb_r;
        lpl_r <= d2c_r[SUM_W-1:0] * best_nb_r;
        rph_r <= best_d2_r[2*SUM_W-1:SUM_W] * cand_nb_r;
        rpl_r <= best_d2_r[SUM_W-1:0] * cand_nb_r;
      end
      S_CMP: begin
        if (take) begin
          best_found_r <= 1'b1;
          best_d2_r    <= d2c_r;
          best_nb_r    <= cand_nb_r;
          best_id_r    <= cand_id_r;
          best_slot_r  <= scan_r;
        end
        if (cand_valid_r && (!old_found_r || (age > old_age_r))) begin
          old_found_r <= 1'b1;
          old_age_r   <= age;
          old_id_r    <= cand_id_r;
          old_slot_r  <= scan_r;
        end
        if (!cand_valid_r && !free_found_r) begin
          free_found_r <= 1'b1;
          free_slot_r  <= scan_r;
        end
        if (cand_valid_r) begin
          count_r <= count_r + CNT_W'(1);
        end
        scan_r <= scan_r + SLOT_W'(1);
      end
      S_T0: begin
        qnnb_r <= qn_r * best_nb_r;
        tts_r  <= same_thresh_r * same_thresh_r;
        ttn_r  <= new_thresh_r * new_thresh_r;
      end
      S_T1: begin
        plo_s_r <= qnnb_r[SUM_W-1:0] * tts_r;
        plo_n_r <= qnnb_r[SUM_W-1:0] * ttn_r;
      end
      S_T2: begin
        phi_s_r <= qnnb_r[2*SUM_W-1:SUM_W] * tts_r;
        phi_n_r <= qnnb_r[2*SUM_W-1:SUM_W] * ttn_r;
      end
      S_T3: begin
        rs_r <= (THR_W'(phi_s_r) << SUM_W) + THR_W'(plo_s_r);
        rn_r <= (THR_W'(phi_n_r) << SUM_W) + THR_W'(plo_n_r);
      end
      S_T4: begin
        gt_same_r <= best_found_r && (d2x > rs_r);
        lt_new_r  <= best_found_r ? (d2x < rn_r) : (new_thresh_r != 16'd0);
      end
      S_DEC: begin
        res_id_r   <= dec_id;
        res_act_r  <= dec_act;
        res_ev_r   <= dec_ev;
        res_evid_r <= dec_ev ? old_id_r : 32'd0;
        store_r    <= dec_store;
        tgt_slot_r <= dec_slot;
      end
      S_POST: begin
        if (post_go) begin
          out_id_r   <= res_id_r;
          out_act_r  <= res_act_r;
          out_ev_r   <= res_ev_r;
          out_evid_r <= res_evid_r;
        end
        cp_r <= '0;
      end
      S_COPY: begin
        cp_d_r  <= cp_r[IDX_W-1:0];
        cp_in_r <= (cp_r < nlen_r);
        if (cp_r != EI_W'(FEATURE_LEN)) begin
          cp_r <= cp_r + EI_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/ctm_checker.sv
`include "cosine_track_matcher_assert.svh"

module ctm_checker import ctm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_track_id,
  input logic [1:0]  out_action,
  input logic        out_evicted,
  input logic [31:0] out_evicted_id
);

  `CTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CTM_ASSERT_SAME(a_match_no_evict, out_valid && (out_action == ACT_MATCH), !out_evicted)
  `CTM_ASSERT_SAME(a_keep_no_evict, out_valid && (out_action == ACT_KEEP), !out_evicted)
  `CTM_ASSERT_SAME(a_evid_zero, out_valid && !out_evicted, out_evicted_id == 32'd0)
  `CTM_ASSERT_SAME(a_new_has_id, out_valid && (out_action == ACT_NEW), out_track_id != 32'd0)

endmodule

bind cosine_track_matcher ctm_checker u_ctm_checker (.*);

// File: bench/tb.sv
module tb;
  import ctm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FL = FEATURE_LEN_DEF;
  localparam int MT = MAX_TRACKS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 3 * MT + FL + 200;

  typedef struct {
    logic signed [7:0] value;
    logic              last;
  } element_t;

  typedef struct {
    logic [31:0] match_id;
    logic [1:0]  action;
    logic        evicted;
    logic [31:0] evicted_id;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [7:0] in_feature_value = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_track_id;
  logic [1:0] out_action;
  logic out_evicted;
  logic [31:0] out_evicted_id;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cosine_track_matcher uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  element_t pending_elems[$];
  verdict_t verdict_q[$];
  int mismatches = 0;
  int cycles = 0;
  int items_queued = 0;
  int act_count[3] = '{0, 0, 0};
  int evict_count = 0;

  // Mirror of the matcher state.
  logic signed [7:0] track_vec[MT][FL];
  logic signed [7:0] query_vec[FL];
  logic slot_used[MT];
  logic [31:0] slot_id[MT];
  logic [31:0] slot_age_mark[MT];
  logic [31:0] id_counter = '0;
  logic [31:0] query_counter = '0;
  int elem_pos = 0;
  logic [6:0] cap_reg = MAX_TRACKS_RST;
  logic [15:0] same_reg = SAME_THRESH_RST;
  logic [15:0] new_reg = NEW_THRESH_RST;

  initial begin
    for (int k = 0; k < MT; k++) begin
      slot_used[k] = 1'b0;
      slot_id[k] = '0;
      slot_age_mark[k] = '0;
      for (int i = 0; i < FL; i++) track_vec[k][i] = '0;
    end
    for (int i = 0; i < FL; i++) query_vec[i] = '0;
  end

  function automatic int thresh_cmp(logic [127:0] d2, logic [127:0] nanb, logic [15:0] t);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = d2 << 32;
    rhs = 128'(t) * 128'(t) * nanb;
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  task automatic absorb_element(input logic signed [7:0] v, input logic last);
    int n;
    int best;
    int count;
    int c;
    int oldest;
    int free_slot;
    int cap;
    longint dot;
    logic [127:0] qn, nb, d2, best_d2, best_nb, lhs, rhs;
    logic [31:0] age, old_age;
    verdict_t r;
    if (elem_pos < FL) begin
      query_vec[elem_pos] = v;
      elem_pos++;
    end
    if (!last) return;
    n = elem_pos;
    elem_pos = 0;
    for (int i = n; i < FL; i++) query_vec[i] = '0;
    qn = '0;
    for (int i = 0; i < FL; i++) qn += 128'(int'(query_vec[i]) * int'(query_vec[i]));
    best = -1;
    count = 0;
    best_d2 = '0;
    best_nb = '0;
    for (int k = 0; k < MT; k++) begin
      if (!slot_used[k]) continue;
      count++;
      dot = 0;
      nb = '0;
      for (int i = 0; i < FL; i++) begin
        dot += longint'(int'(query_vec[i]) * int'(track_vec[k][i]));
        nb += 128'(int'(track_vec[k][i]) * int'(track_vec[k][i]));
      end
      if (dot <= 0 || nb == 0 || qn == 0) continue;
      d2 = 128'(dot) * 128'(dot);
      if (best < 0) begin
        c = 1;
      end else begin
        lhs = d2 * best_nb;
        rhs = best_d2 * nb;
        c = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
        if (c == 0 && slot_id[k] < slot_id[best]) c = 1;
      end
      if (c > 0) begin
        best = k;
        best_d2 = d2;
        best_nb = nb;
      end
    end
    query_counter++;
    r.evicted = 1'b0;
    r.evicted_id = '0;
    if (best >= 0 && thresh_cmp(best_d2, qn * best_nb, same_reg) > 0) begin
      for (int i = 0; i < FL; i++) track_vec[best][i] = query_vec[i];
      slot_age_mark[best] = query_counter;
      r.match_id = slot_id[best];
      r.action = ACT_MATCH;
    end else if (best >= 0 ? thresh_cmp(best_d2, qn * best_nb, new_reg) < 0 : new_reg > 0) begin
      cap = (cap_reg == 0) ? 1 : ((cap_reg > MT) ? MT : cap_reg);
      if (count >= cap) begin
        oldest = -1;
        old_age = '0;
        for (int k = 0; k < MT; k++) begin
          age = query_counter - slot_age_mark[k];
          if (slot_used[k] && (oldest < 0 || age > old_age)) begin
            oldest = k;
            old_age = age;
          end
        end
        if (oldest >= 0) begin
          slot_used[oldest] = 1'b0;
          r.evicted = 1'b1;
          r.evicted_id = slot_id[oldest];
        end
      end
      free_slot = -1;
      for (int k = 0; k < MT; k++) begin
        if (!slot_used[k] && free_slot < 0) free_slot = k;
      end
      id_counter++;
      if (id_counter == 0) id_counter = 1;
      r.match_id = id_counter;
      if (free_slot >= 0) begin
        for (int i = 0; i < FL; i++) track_vec[free_slot][i] = query_vec[i];
        slot_used[free_slot] = 1'b1;
        slot_id[free_slot] = id_counter;
        slot_age_mark[free_slot] = query_counter;
      end
      r.action = ACT_NEW;
    end else begin
      r.match_id = (best >= 0) ? slot_id[best] : 32'd0;
      r.action = ACT_KEEP;
    end
    verdict_q = {verdict_q, r};
  endtask

  // Driver: bursts of items separated by random gaps.
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk) begin
    element_t e;
    if (rst_n) begin
      if (in_valid && in_ready) absorb_element(in_feature_value, in_last_element);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          e = pending_elems.pop_front();
          in_valid <= 1'b1;
          in_feature_value <= e.value;
          in_last_element <= e.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern.
  int stall_mode = 0;
  always @(posedge clk) begin
    verdict_t x;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: id=%0d action=%0d", out_track_id,
                                       out_action);
      end else begin
        x = verdict_q.pop_front();
        act_count[x.action]++;
        if (x.evicted) evict_count++;
        if (out_track_id !== x.match_id || out_action !== x.action ||
            out_evicted !== x.evicted || out_evicted_id !== x.evicted_id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d (id/act/ev/evid)",
                     x.match_id, x.action, x.evicted, x.evicted_id, out_track_id,
                     out_action, out_evicted, out_evicted_id);
        end
      end
    end
    if (cycles % 700 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= (cycles % 9) < 3;
    endcase
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_TRACKS: cap_reg = value[6:0];
      REG_SAME_THRESH: same_reg = value[15:0];
      default: new_reg = value[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending_elems.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_query(input logic signed [7:0] vals[$]);
    element_t e;
    for (int i = 0; i < vals.size(); i++) begin
      e.value = vals[i];
      e.last = (i == vals.size() - 1);
      pending_elems = {pending_elems, e};
      items_queued++;
    end
  endtask

  function automatic logic signed [7:0] clip8(int x);
    return (x > 127) ? 8'sd127 : ((x < -128) ? -8'sd128 : 8'(x));
  endfunction

  logic signed [7:0] pattern_bank[8][FL];

  task automatic random_queries(input int item_goal);
    logic signed [7:0] q[$];
    int len;
    int kind;
    int pick;
    int noise;
    int goal;
    goal = items_queued + item_goal;
    while (items_queued < goal) begin
      q.delete();
      kind = $urandom_range(0, 99);
      len = $urandom_range(2, 20);
      if ($urandom_range(0, 39) == 0) len = FL;
      if ($urandom_range(0, 49) == 0) len = FL + $urandom_range(1, 30);
      if ($urandom_range(0, 29) == 0) len = 1;
      pick = $urandom_range(0, 7);
      noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
        if (kind < 75) q = {q, clip8(int'(pattern_bank[pick][i % FL]) +
                                     $urandom_range(0, 2 * noise) - noise)};
        else if (kind < 82) q = {q, 8'sd0};
        else if (kind < 88) q = {q, (($urandom_range(0, 1) == 0) ? -8'sd128 : 8'sd127)};
        else q = {q, 8'($urandom_range(0, 255))};
      end
      push_query(q);
    end
  endtask

  initial begin
    logic signed [7:0] q[$];
    for (int b = 0; b < 8; b++)
      for (int i = 0; i < FL; i++)
        pattern_bank[b][i] = ($urandom_range(0, 4) == 0) ? 8'sd0 : 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero vector, tie between two orthogonal tracks.
    q = '{8'sd127, -8'sd128};
    push_query(q);
    q = '{8'sd0, 8'sd0};
    push_query(q);
    q = '{-8'sd128, 8'sd127};
    push_query(q);
    q = '{8'sd0, 8'sd0, 8'sd5};
    push_query(q);
    q = '{8'sd0, 8'sd0, 8'sd0, 8'sd9};
    push_query(q);
    q = '{8'sd0, 8'sd0, 8'sd7, 8'sd7};
    push_query(q);
    q = '{8'sd127};
    push_query(q);
    q = '{-8'sd1, -8'sd1};
    push_query(q);
    drain();

    reg_write(REG_MAX_TRACKS, 32'd3);
    reg_write(REG_SAME_THRESH, 32'd50000);
    reg_write(REG_NEW_THRESH, 32'd40000);
    random_queries(200);
    drain();
    random_queries(150);
    drain();

    reg_write(REG_MAX_TRACKS, 32'd0);
    reg_write(REG_SAME_THRESH, 32'd65535);
    reg_write(REG_NEW_THRESH, 32'd65535);
    random_queries(250);
    drain();

    reg_write(REG_MAX_TRACKS, 32'd127);
    reg_write(REG_SAME_THRESH, 32'd0);
    reg_write(REG_NEW_THRESH, 32'd0);
    random_queries(250);
    drain();

    reg_write(REG_MAX_TRACKS, 32'd1);
    reg_write(REG_SAME_THRESH, 32'd30000);
    reg_write(REG_NEW_THRESH, 32'd60000);
    random_queries(250);
    drain();

    reg_write(REG_MAX_TRACKS, 32'd64);
    reg_write(REG_SAME_THRESH, 32'd58982);
    reg_write(REG_NEW_THRESH, 32'd19661);
    random_queries(300);
    drain();

    reg_write(REG_MAX_TRACKS, 32'($urandom_range(2, 12)));
    reg_write(REG_SAME_THRESH, 32'($urandom_range(0, 65535)));
    reg_write(REG_NEW_THRESH, 32'($urandom_range(0, 65535)));
    random_queries(350);
    drain();

    $display("Sent %0d items; results: %0d matched, %0d new, %0d unchanged, %0d evictions.",
             items_queued, act_count[0], act_count[1], act_count[2], evict_count);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
